// ===== rtl/core/kteq_pkg.sv =====
// Package for the keyed timed event queue: widths, mode and status codes.
// No dependencies.
package kteq_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W = 28;
  localparam int DUE_W = 32;
  localparam int ACT_W = 16;
  localparam logic [15:0] TICK_RESET = 16'd100;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;
endpackage

// ===== rtl/core/keyed_timed_event_queue_unit.sv =====
// Top level of the keyed timed event queue: slot store, order list, sequencer.
// Depends on kteq_pkg.
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid/in_tready    | in_tdata, in_tuser (mode)
//  out_    | master    | out_tvalid/out_tready  | out_tdata, out_tuser (status), out_tlast
//  cfg_    | write     | cfg_we                 | cfg_wdata (tick_period)
//
// Key scan: one slot key is read and compared at a time. A new insert runs a shift-add
// multiply, a saturate step, a binary search of the due times (stopping on an equal one),
// a shift of the order positions from the end down to the insert point, and an emit. A
// removal walks the order list for the position and closes the gap, moves the last slot
// into the hole and relabels it, then emits. A tick checks the head due time; each pop
// adds a removal without the key scan, an emit and a second head check. Reset idles the
// sequencer, clears the count, the pending flag and the output valid, and sets the tick
// period to TICK_RESET. The block takes no word while busy and waits on out_tready.
module keyed_timed_event_queue_unit #(
  parameter int CAPACITY = kteq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: section_id[15:0], cell_offset[27:16], delay_ticks[43:28],
  // action_code[59:44], now_time[91:60], zero fill
  input  logic [95:0] in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: out_section[15:0], out_offset[27:16], out_action[43:28],
  // pending_count[50:44], zero fill
  output logic [55:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_SCAN = 5'd1,  S_SCANW = 5'd2,
                         S_MUL  = 5'd3,  S_SAT  = 5'd4,  S_BS0   = 5'd5,
                         S_BS1  = 5'd6,  S_BS2  = 5'd7,  S_INS   = 5'd8,
                         S_INSW = 5'd9,  S_DF0  = 5'd10, S_DF1   = 5'd11,
                         S_DSH  = 5'd12, S_DSW  = 5'd13, S_DMV   = 5'd14,
                         S_DMW  = 5'd15, S_DRL  = 5'd16, S_DRW   = 5'd17,
                         S_TK0  = 5'd18, S_TK1  = 5'd19, S_TK2   = 5'd20,
                         S_EMIT = 5'd21;

  // slot store and order list
  logic [kteq_pkg::KEY_W-1:0] key_mem [CAPACITY];
  logic [kteq_pkg::DUE_W-1:0] due_mem [CAPACITY];
  logic [kteq_pkg::ACT_W-1:0] act_mem [CAPACITY];
  logic [IW-1:0]              ord_mem [CAPACITY];

  logic [4:0]    state_r, ret_r;
  logic [15:0]   tick_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    mode_r;
  logic [15:0]   sec_r;
  logic [11:0]   off_r;
  logic [15:0]   dly_r, act_r;
  logic [31:0]   now_r;
  logic [31:0]   acc_r, mc_r;
  logic [3:0]    mstep_r;
  logic [CW-1:0] i_r, lo_r, hi_r, mid_r;
  logic [IW-1:0] slot_r, lastslot_r;
  logic          pend_r;
  logic [kteq_pkg::KEY_W-1:0] krd_r;
  logic [kteq_pkg::DUE_W-1:0] drd_r;
  logic [kteq_pkg::ACT_W-1:0] ard_r;
  logic [IW-1:0]              ord_rd_r;
  logic [31:0]   due_r;
  // staged result
  logic [1:0]    est_r;
  logic [15:0]   esec_r, eact_r;
  logic [11:0]   eoff_r;
  logic          elast_r;
  // output register
  logic          ov_r, olast_r;
  logic [1:0]    ost_r;
  logic [15:0]   osec_r, oact_r;
  logic [11:0]   ooff_r;
  logic [CW-1:0] ocnt_r;

  logic [kteq_pkg::KEY_W-1:0] key_in;
  logic [CW:0]   midsum;
  logic [32:0]   dsum;
  logic          emit;

  assign key_in     = {sec_r, off_r};
  assign midsum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign dsum       = {1'b0, now_r} + {1'b0, acc_r};
  assign emit       = (state_r == S_EMIT) && (!ov_r || out_tready);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, 7'(ocnt_r), oact_r, ooff_r, osec_r};

  // memory ports: one read address per store per cycle, registered data
  logic [IW-1:0] kra, dra, ora, wa, owa;
  logic          ewe, awe, owe;
  logic [kteq_pkg::KEY_W-1:0] kwd;
  logic [31:0]   dwd;
  logic [15:0]   awd;
  logic [IW-1:0] owd;

  always_ff @(posedge clk) begin
    krd_r    <= key_mem[kra];
    drd_r    <= due_mem[dra];
    ard_r    <= act_mem[dra];
    ord_rd_r <= ord_mem[ora];
    if (ewe) begin
      key_mem[wa] <= kwd;
      due_mem[wa] <= dwd;
    end
    if (ewe || awe) act_mem[wa] <= awd;
    if (owe) ord_mem[owa] <= owd;
  end

  // pick addresses and writes for the current step
  always_comb begin
    kra = i_r[IW-1:0];
    dra = i_r[IW-1:0];
    ora = i_r[IW-1:0];
    wa  = slot_r;
    owa = i_r[IW-1:0];
    ewe = 1'b0; awe = 1'b0; owe = 1'b0;
    kwd = key_in; dwd = due_r; awd = act_r; owd = ord_rd_r;
    case (state_r)
      S_SCANW: if (krd_r == key_in && mode_r == kteq_pkg::MODE_INSERT) begin
        awe = 1'b1; wa = i_r[IW-1:0];
      end
      S_BS0: ora = midsum[IW:1];
      S_BS1: dra = ord_rd_r;
      S_INS: begin
        if (i_r == lo_r) begin
          ewe = 1'b1; wa = cnt_r[IW-1:0];
          owe = 1'b1; owa = lo_r[IW-1:0]; owd = cnt_r[IW-1:0];
        end else begin
          ora = IW'(i_r - ONE_C);
        end
      end
      S_INSW: owe = 1'b1;
      S_DSH: ora = IW'(i_r + ONE_C);
      S_DSW: owe = 1'b1;
      S_DMV: begin kra = lastslot_r; dra = lastslot_r; end
      S_DMW: begin
        ewe = 1'b1; kwd = krd_r; dwd = drd_r; awd = ard_r;
      end
      S_DRW: if (ord_rd_r == lastslot_r) begin
        owe = 1'b1; owd = slot_r;
      end
      S_TK0: ora = '0;
      S_TK1: begin ora = '0; kra = ord_rd_r; dra = ord_rd_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; tick_r <= kteq_pkg::TICK_RESET; cnt_r <= '0;
      ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      if (cfg_we) tick_r <= cfg_wdata;
      // load or drop the output word
      if (emit) begin
        ov_r <= 1'b1; olast_r <= elast_r; ost_r <= est_r; osec_r <= esec_r;
        ooff_r <= eoff_r; oact_r <= eact_r; ocnt_r <= cnt_r;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          mode_r <= in_tuser; sec_r <= in_tdata[15:0]; off_r <= in_tdata[27:16];
          dly_r <= in_tdata[43:28]; act_r <= in_tdata[59:44]; now_r <= in_tdata[91:60];
          esec_r <= in_tdata[15:0]; eoff_r <= in_tdata[27:16]; eact_r <= '0;
          elast_r <= 1'b1; est_r <= kteq_pkg::ST_DONE;
          i_r <= '0; pend_r <= 1'b0;
          state_r <= (in_tuser == kteq_pkg::MODE_TICK) ? S_TK0 : S_SCAN;
        end
        // scan keys one slot at a time
        S_SCAN: begin
          if (i_r >= cnt_r) begin
            if (mode_r == kteq_pkg::MODE_INSERT) begin
              if (cnt_r >= CAP_C) begin
                est_r <= kteq_pkg::ST_FULL; state_r <= S_EMIT;
              end else begin
                acc_r <= '0; mc_r <= {16'd0, tick_r}; mstep_r <= '0; state_r <= S_MUL;
              end
            end else begin
              est_r <= kteq_pkg::ST_NOTFOUND; state_r <= S_EMIT;
            end
          end else begin
            state_r <= S_SCANW;
          end
        end
        S_SCANW: begin
          if (krd_r == key_in) begin
            slot_r <= i_r[IW-1:0];
            if (mode_r == kteq_pkg::MODE_REMOVE) begin
              i_r <= '0; ret_r <= S_EMIT; state_r <= S_DF0;
            end else begin
              state_r <= S_EMIT;
            end
          end else begin
            i_r <= i_r + ONE_C; state_r <= S_SCAN;
          end
        end
        // shift-add multiply delay by tick period
        S_MUL: begin
          if (dly_r[0]) acc_r <= acc_r + mc_r;
          dly_r <= dly_r >> 1; mc_r <= mc_r << 1; mstep_r <= mstep_r + 4'd1;
          if (mstep_r == 4'd15) state_r <= S_SAT;
        end
        // saturate due, then start the binary search
        S_SAT: begin
          due_r <= dsum[32] ? '1 : dsum[31:0];
          lo_r <= '0; hi_r <= cnt_r; state_r <= S_BS0;
        end
        S_BS0: begin
          if (lo_r >= hi_r) begin
            i_r <= cnt_r; state_r <= S_INS;
          end else begin
            mid_r <= midsum[CW:1]; state_r <= S_BS1;
          end
        end
        S_BS1: state_r <= S_BS2;
        // compare probe due time, stop on an equal one
        S_BS2: begin
          if (drd_r == due_r) begin
            lo_r <= mid_r; hi_r <= mid_r;
          end else if (drd_r < due_r) begin
            lo_r <= mid_r + ONE_C;
          end else begin
            hi_r <= mid_r;
          end
          state_r <= S_BS0;
        end
        // shift order list up from the end down to lo, then place the entry
        S_INS: begin
          if (i_r == lo_r) begin
            cnt_r <= cnt_r + ONE_C; state_r <= S_EMIT;
          end else begin
            state_r <= S_INSW;
          end
        end
        S_INSW: begin
          i_r <= i_r - ONE_C; state_r <= S_INS;
        end
        // delete slot_r: find its position
        S_DF0: state_r <= S_DF1;
        S_DF1: begin
          if (ord_rd_r == slot_r || i_r + ONE_C >= cnt_r) begin
            state_r <= S_DSH;
          end else begin
            i_r <= i_r + ONE_C; state_r <= S_DF0;
          end
        end
        // close the gap in the order list
        S_DSH: begin
          if (i_r + ONE_C >= cnt_r) begin
            cnt_r <= cnt_r - ONE_C; lastslot_r <= IW'(cnt_r - ONE_C);
            state_r <= (slot_r != IW'(cnt_r - ONE_C)) ? S_DMV : ret_r;
          end else begin
            state_r <= S_DSW;
          end
        end
        S_DSW: begin
          i_r <= i_r + ONE_C; state_r <= S_DSH;
        end
        // move the last slot into the hole and relabel it
        S_DMV: state_r <= S_DMW;
        S_DMW: begin
          i_r <= '0; state_r <= S_DRL;
        end
        S_DRL: state_r <= (i_r >= cnt_r) ? ret_r : S_DRW;
        S_DRW: begin
          if (ord_rd_r == lastslot_r) begin
            state_r <= ret_r;
          end else begin
            i_r <= i_r + ONE_C; state_r <= S_DRL;
          end
        end
        // tick: read head order, then its entry
        S_TK0: begin
          if (cnt_r == '0) begin
            if (!pend_r) est_r <= kteq_pkg::ST_NONE;
            elast_r <= 1'b1; state_r <= S_EMIT;
          end else begin
            state_r <= S_TK1;
          end
        end
        S_TK1: state_r <= S_TK2;
        S_TK2: begin
          if (drd_r > now_r) begin
            if (!pend_r) est_r <= kteq_pkg::ST_NONE;
            elast_r <= 1'b1; state_r <= S_EMIT;
          end else if (pend_r) begin
            // another entry is due: send the held one as not last
            elast_r <= 1'b0; pend_r <= 1'b0; state_r <= S_EMIT;
          end else begin
            esec_r <= krd_r[27:12]; eoff_r <= krd_r[11:0]; eact_r <= ard_r;
            slot_r <= ord_rd_r; pend_r <= 1'b1; i_r <= '0;
            ret_r <= S_TK0; state_r <= S_DF0;
          end
        end
        S_EMIT: if (!ov_r || out_tready) begin
          state_r <= elast_r ? S_IDLE : S_TK0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
